>>> rtl/core/gia_pkg.sv
// Package for the generational ID allocator.
// Holds pool geometry, request/status codes and the controller state type.
// No dependencies.
package gia_pkg;

    localparam int POOL_SIZE = 1024;
    localparam int GEN_BITS  = 16;
    localparam int IDX_BITS  = $clog2(POOL_SIZE);
    localparam int CNT_BITS  = IDX_BITS + 1;

    typedef enum logic [1:0] {
        REQ_CREATE = 2'd0,
        REQ_REMOVE = 2'd1,
        REQ_GET    = 2'd2,
        REQ_CHECK  = 2'd3
    } req_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_EXHAUSTED  = 2'd1,
        STAT_BAD_INDEX  = 2'd2,
        STAT_STACK_FULL = 2'd3
    } status_t;

    typedef enum logic {
        S_IDLE = 1'b0,
        S_EXEC = 1'b1
    } state_t;

endpackage

>>> rtl/core/gia_ram.sv
// Generic simple dual-port RAM: one write port, one registered read port.
// Used for the generation table and the free stack. No dependencies.
module gia_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/generational_id_allocator_top.sv
// Generational ID allocator: generation table plus LIFO stack of freed handles.
// Depends on gia_pkg and gia_ram.
//
//  channel   dir  handshake             payload
//  request   in   in_valid / in_ready   req_type, handle_index, handle_generation
//  result    out  out_valid / out_ready out_index, out_generation, is_valid, status
//
// Each request is accepted in S_IDLE, which launches the registered reads of
// the generation table and the free stack; in S_EXEC the request modifies,
// writes back and loads the result register. A request holds in S_EXEC while
// the result register is full and not taken. Reset needs no clearing pass: table
// entries at or above the fresh index were never written and read as zero.
module generational_id_allocator_top
    import gia_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic [1:0]          req_type,
    input  logic [IDX_BITS-1:0] handle_index,
    input  logic [GEN_BITS-1:0] handle_generation,
    output logic                out_valid,
    input  logic                out_ready,
    output logic [IDX_BITS-1:0] out_index,
    output logic [GEN_BITS-1:0] out_generation,
    output logic                is_valid,
    output status_t             status
);

    state_t state_reg, state_next;

    logic [CNT_BITS-1:0] count_reg, count_next;
    logic [CNT_BITS-1:0] fresh_reg, fresh_next;

    req_t                req_reg;
    logic [IDX_BITS-1:0] idx_reg;
    logic [GEN_BITS-1:0] gen_reg;

    logic                out_valid_reg;
    logic [IDX_BITS-1:0] out_index_reg;
    logic [GEN_BITS-1:0] out_gen_reg;
    logic                is_valid_reg;
    status_t             status_reg;

    logic                accept;
    logic                out_free;
    logic                finish;

    logic                tbl_we;
    logic [IDX_BITS-1:0] tbl_waddr;
    logic [GEN_BITS-1:0] tbl_wdata;
    logic [GEN_BITS-1:0] tbl_rdata;

    logic                         stk_we;
    logic [IDX_BITS+GEN_BITS-1:0] stk_wdata;
    logic [IDX_BITS+GEN_BITS-1:0] stk_rdata;
    logic [CNT_BITS-1:0]          cnt_dec;

    logic                in_range;
    logic [GEN_BITS-1:0] stored;
    logic [GEN_BITS-1:0] gen_inc;

    logic [IDX_BITS-1:0] res_index;
    logic [GEN_BITS-1:0] res_gen;
    logic                res_valid;
    status_t             res_status;

    // ---------------- memories ----------------
    gia_ram #(
        .WIDTH (GEN_BITS),
        .DEPTH (POOL_SIZE)
    ) u_gen_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .re    (accept),
        .raddr (handle_index),
        .rdata (tbl_rdata)
    );

    assign cnt_dec = count_reg - CNT_BITS'(1);

    gia_ram #(
        .WIDTH (IDX_BITS + GEN_BITS),
        .DEPTH (POOL_SIZE)
    ) u_free_stack (
        .clk   (clk),
        .we    (stk_we),
        .waddr (count_reg[IDX_BITS-1:0]),
        .wdata (stk_wdata),
        .re    (accept),
        .raddr (cnt_dec[IDX_BITS-1:0]),
        .rdata (stk_rdata)
    );

    // ---------------- control FSM ----------------
    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        finish   = 1'b0;
        unique case (state_reg)
            S_IDLE:  in_ready = 1'b1;
            S_EXEC:  finish   = out_free;
            default: in_ready = 1'b0;
        endcase
    end

    assign accept = in_valid && in_ready;

    // ---------------- read-modify-write ----------------
    // Entries at or above the fresh index were never written: they read as zero.
    assign in_range = (idx_reg != '0) && ({1'b0, idx_reg} < fresh_reg);
    assign stored   = ({1'b0, idx_reg} < fresh_reg) ? tbl_rdata : '0;
    assign gen_inc  = tbl_rdata + GEN_BITS'(1);

    always_comb
    begin
        res_index  = idx_reg;
        res_gen    = '0;
        res_valid  = 1'b0;
        res_status = STAT_OK;
        count_next = count_reg;
        fresh_next = fresh_reg;
        tbl_we     = 1'b0;
        tbl_waddr  = idx_reg;
        tbl_wdata  = gen_inc;
        stk_we     = 1'b0;
        stk_wdata  = {idx_reg, gen_inc};
        unique case (req_reg)
            REQ_CREATE:
            begin
                if (count_reg != '0)
                begin
                    res_index  = stk_rdata[IDX_BITS+GEN_BITS-1:GEN_BITS];
                    res_gen    = stk_rdata[GEN_BITS-1:0];
                    count_next = cnt_dec;
                end
                else if (!fresh_reg[IDX_BITS])
                begin
                    res_index  = fresh_reg[IDX_BITS-1:0];
                    res_gen    = GEN_BITS'(1);
                    tbl_we     = 1'b1;
                    tbl_waddr  = fresh_reg[IDX_BITS-1:0];
                    tbl_wdata  = GEN_BITS'(1);
                    fresh_next = fresh_reg + CNT_BITS'(1);
                end
                else
                begin
                    res_index  = '0;
                    res_status = STAT_EXHAUSTED;
                end
            end
            REQ_REMOVE:
            begin
                if (!in_range)
                begin
                    res_status = STAT_BAD_INDEX;
                end
                else if (count_reg[IDX_BITS])
                begin
                    res_status = STAT_STACK_FULL;
                end
                else
                begin
                    res_gen    = gen_inc;
                    tbl_we     = 1'b1;
                    stk_we     = 1'b1;
                    count_next = count_reg + CNT_BITS'(1);
                end
            end
            REQ_GET, REQ_CHECK:
            begin
                if (idx_reg == '0)
                begin
                    res_status = STAT_BAD_INDEX;
                end
                else
                begin
                    res_gen   = stored;
                    res_valid = (req_reg == REQ_CHECK) && (gen_reg == stored)
                                && (gen_reg != '0);
                end
            end
            default:
            begin
                res_status = STAT_OK;
            end
        endcase
        if (!finish)
        begin
            tbl_we     = 1'b0;
            stk_we     = 1'b0;
            count_next = count_reg;
            fresh_next = fresh_reg;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            fresh_reg     <= CNT_BITS'(1);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            fresh_reg <= fresh_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            req_reg <= req_t'(req_type);
            idx_reg <= handle_index;
            gen_reg <= handle_generation;
        end
        if (finish)
        begin
            out_index_reg <= res_index;
            out_gen_reg   <= res_gen;
            is_valid_reg  <= res_valid;
            status_reg    <= res_status;
        end
    end

    assign out_valid      = out_valid_reg;
    assign out_index      = out_index_reg;
    assign out_generation = out_gen_reg;
    assign is_valid       = is_valid_reg;
    assign status         = status_reg;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_BITS'(POOL_SIZE))
        else $error("free stack count above pool size");

    a_fresh_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fresh_reg != '0) && (fresh_reg <= CNT_BITS'(POOL_SIZE)))
        else $error("fresh index out of range");

    a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !in_ready)
        else $error("request accepted while another is in flight");

    a_valid_result: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && is_valid) |-> ((status == STAT_OK) && (out_generation != '0)))
        else $error("live handle reported with bad status or zero generation");
`endif

endmodule

>>> tb/sv/tb.sv
// Testbench for generational_id_allocator_top: directed and random request streams
// against a cycle-free model of the handle allocator, with random stalls on both sides.
// Depends on gia_pkg and the allocator RTL.
`timescale 1ns / 100ps

module tb;
    import gia_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 400;

    typedef struct packed {
        logic [IDX_BITS-1:0] index;
        logic [GEN_BITS-1:0] generation;
        logic                live;
        status_t             status;
    } handle_result_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_ready;
    logic [1:0]          req_type;
    logic [IDX_BITS-1:0] handle_index;
    logic [GEN_BITS-1:0] handle_generation;
    logic                out_valid;
    logic                out_ready;
    logic [IDX_BITS-1:0] out_index;
    logic [GEN_BITS-1:0] out_generation;
    logic                is_valid;
    status_t             status;

    // allocator model state
    logic [GEN_BITS-1:0] gen_table [POOL_SIZE];
    logic [IDX_BITS-1:0] freed_idx [POOL_SIZE];
    logic [GEN_BITS-1:0] freed_gen [POOL_SIZE];
    int                  freed_count;
    int                  fresh_next;

    handle_result_t      pending_results[$];
    handle_result_t      want;
    int                  fail_count;
    int                  quiet_cycles;
    bit                  idle_en;
    bit                  sink_hold_go;

    generational_id_allocator_top u_dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .in_valid          (in_valid),
        .in_ready          (in_ready),
        .req_type          (req_type),
        .handle_index      (handle_index),
        .handle_generation (handle_generation),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_index         (out_index),
        .out_generation    (out_generation),
        .is_valid          (is_valid),
        .status            (status)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic handle_result_t predict_alloc(req_t rt, logic [IDX_BITS-1:0] idx,
                                                     logic [GEN_BITS-1:0] gen);
        handle_result_t r;
        r = '{index: idx, generation: '0, live: 1'b0, status: STAT_OK};
        case (rt)
            REQ_CREATE:
            begin
                if (freed_count > 0)
                begin
                    freed_count--;
                    r.index      = freed_idx[freed_count];
                    r.generation = freed_gen[freed_count];
                end
                else if (fresh_next < POOL_SIZE)
                begin
                    r.index              = IDX_BITS'(fresh_next);
                    r.generation         = GEN_BITS'(1);
                    gen_table[fresh_next] = GEN_BITS'(1);
                    fresh_next++;
                end
                else
                begin
                    r.index  = '0;
                    r.status = STAT_EXHAUSTED;
                end
            end
            REQ_REMOVE:
            begin
                if (idx == 0 || idx >= fresh_next)
                    r.status = STAT_BAD_INDEX;
                else if (freed_count >= POOL_SIZE)
                    r.status = STAT_STACK_FULL;
                else
                begin
                    gen_table[idx]         = gen_table[idx] + 1'b1;
                    freed_idx[freed_count] = idx;
                    freed_gen[freed_count] = gen_table[idx];
                    freed_count++;
                    r.generation = gen_table[idx];
                end
            end
            default:
            begin
                if (idx == 0)
                    r.status = STAT_BAD_INDEX;
                else
                begin
                    r.generation = gen_table[idx];
                    r.live = (rt == REQ_CHECK) && (gen == gen_table[idx]) && (gen != 0);
                end
            end
        endcase
        return r;
    endfunction

    // Leaves in_valid high on return; the caller either sends again or lowers it
    // in the same time step.
    task automatic send_req(req_t rt, logic [IDX_BITS-1:0] idx, logic [GEN_BITS-1:0] gen);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 11);
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid          <= 1'b1;
        req_type          <= rt;
        handle_index      <= idx;
        handle_generation <= gen;
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(predict_alloc(rt, idx, gen));
        @(negedge clk);
    endtask

    task automatic test_basic_ops();
        send_req(REQ_GET,    10'd5,    16'd0);
        send_req(REQ_REMOVE, 10'd0,    16'd0);
        send_req(REQ_REMOVE, 10'd1,    16'd1);
        send_req(REQ_CREATE, 10'd0,    16'd0);
        send_req(REQ_CREATE, 10'h3ff,  16'hffff);
        send_req(REQ_CHECK,  10'd1,    16'd1);
        send_req(REQ_CHECK,  10'd1,    16'd2);
        send_req(REQ_CHECK,  10'd1,    16'd0);
        send_req(REQ_CHECK,  10'd0,    16'd0);
        send_req(REQ_GET,    10'd0,    16'hffff);
        send_req(REQ_GET,    10'h3ff,  16'd0);
        send_req(REQ_CHECK,  10'h3ff,  16'hffff);
        send_req(REQ_REMOVE, 10'd1,    16'd0);
        send_req(REQ_REMOVE, 10'd1,    16'h1234);   // double remove
        send_req(REQ_CHECK,  10'd1,    16'd1);      // stale handle
        send_req(REQ_REMOVE, 10'h3ff,  16'd0);      // never issued
        send_req(REQ_CREATE, 10'd0,    16'd0);
        send_req(REQ_CREATE, 10'd0,    16'd0);
        send_req(REQ_CREATE, 10'd0,    16'd0);
        send_req(REQ_GET,    10'd1,    16'd0);
        send_req(REQ_CHECK,  10'd1,    16'd3);
        send_req(REQ_REMOVE, 10'd2,    16'hffff);
        send_req(REQ_CHECK,  10'd2,    16'd2);
    endtask

    task automatic test_random_mix(int count);
        int                  pick;
        req_t                rt;
        logic [IDX_BITS-1:0] idx;
        logic [GEN_BITS-1:0] g;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(0, 9);
            case (pick)
                0, 1, 2: rt = REQ_CREATE;
                3, 4, 5: rt = REQ_REMOVE;
                6:       rt = REQ_GET;
                default: rt = REQ_CHECK;
            endcase
            pick = $urandom_range(0, 9);
            if (pick == 0)
                idx = '0;
            else if (pick == 1 || fresh_next <= 1)
                idx = IDX_BITS'($urandom);
            else
                idx = IDX_BITS'($urandom_range(1, fresh_next - 1));
            pick = $urandom_range(0, 9);
            if (pick < 5)
                g = gen_table[idx];
            else if (pick < 7)
                g = gen_table[idx] + GEN_BITS'($urandom_range(0, 2)) - 1'b1;
            else
                g = GEN_BITS'($urandom);
            send_req(rt, idx, g);
        end
    endtask

    task automatic test_random_idling();
        for (int chunk = 0; chunk < 9; chunk++)
        begin
            idle_en = ($urandom_range(0, 3) != 0);
            test_random_mix(30);
        end
        idle_en = 1'b0;
    endtask

    // result side stalls for a long stretch while requests keep coming
    task automatic test_output_backpressure();
        sink_hold_go = 1'b1;
        test_random_mix(24);
    endtask

    task automatic test_pool_exhaustion();
        while (!(freed_count == 0 && fresh_next >= POOL_SIZE))
            send_req(REQ_CREATE, IDX_BITS'($urandom), GEN_BITS'($urandom));
        send_req(REQ_CREATE, 10'd0, 16'd0);
        send_req(REQ_CREATE, 10'h3ff, 16'hffff);
        send_req(REQ_CHECK, 10'h3ff, 16'd1);
        send_req(REQ_REMOVE, 10'h3ff, 16'd0);
        send_req(REQ_CREATE, 10'd0, 16'd0);
    endtask

    task automatic finish_run();
        in_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (fail_count == 0 && pending_results.size() == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    endtask

    // result sink: random stalls, plus one long hold on request
    initial
    begin : result_sink
        int gap;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (sink_hold_go)
            begin
                out_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
                sink_hold_go = 1'b0;
            end
            else if (idle_en && $urandom_range(0, 7) == 0)
            begin
                gap = $urandom_range(1, 11);
                out_ready <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with no request pending: out_index %0d out_generation %0d",
                       out_index, out_generation);
                fail_count++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_index !== want.index)
                begin
                    $error("out_index: expected %0d, got %0d", want.index, out_index);
                    fail_count++;
                end
                if (out_generation !== want.generation)
                begin
                    $error("out_generation: expected %0d, got %0d",
                           want.generation, out_generation);
                    fail_count++;
                end
                if (is_valid !== want.live)
                begin
                    $error("is_valid: expected %0d, got %0d", want.live, is_valid);
                    fail_count++;
                end
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    fail_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("tb: done, errors");
            $finish;
        end
    end

    initial
    begin
        rst_n             = 1'b0;
        in_valid          = 1'b0;
        req_type          = REQ_CREATE;
        handle_index      = '0;
        handle_generation = '0;
        fail_count        = 0;
        quiet_cycles      = 0;
        idle_en           = 1'b0;
        sink_hold_go      = 1'b0;
        freed_count       = 0;
        fresh_next        = 1;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            gen_table[i] = '0;
            freed_idx[i] = '0;
            freed_gen[i] = '0;
        end
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        idle_en = 1'b1;
        test_basic_ops();
        test_random_idling();
        test_output_backpressure();
        test_pool_exhaustion();
        test_random_mix(60);
        finish_run();
    end

endmodule

>>> sim.f
rtl/core/gia_pkg.sv
rtl/core/gia_ram.sv
rtl/core/generational_id_allocator_top.sv
tb/sv/tb.sv
